// ===== design/dxam_pkg.sv =====
// ----------------------------------------------------------------------------
// dxam_pkg
// Shared types and constants of the DRAM XOR address mapper: field widths,
// slot layout, request kinds and the packed stream payloads.
// ----------------------------------------------------------------------------
package dxam_pkg;

  // Address and component widths
  localparam int unsigned ADDR_BITS      = 40;
  localparam int unsigned COL_BITS       = 12;
  localparam int unsigned ROW_BITS       = 18;
  localparam int unsigned BANK_BITS      = 3;
  localparam int unsigned BANKGROUP_BITS = 2;
  localparam int unsigned RANK_CHAN_BITS = 2;
  localparam int unsigned OFFSET_W       = 4;
  localparam int unsigned BURST_W        = 15;

  // Slot layout: column bits first, then row, bank, bankgroup, rank, channel
  localparam int unsigned COL_BASE   = 0;
  localparam int unsigned ROW_BASE   = COL_BASE + COL_BITS;
  localparam int unsigned BANK_BASE  = ROW_BASE + ROW_BITS;
  localparam int unsigned BG_BASE    = BANK_BASE + BANK_BITS;
  localparam int unsigned RANK_BASE  = BG_BASE + BANKGROUP_BITS;
  localparam int unsigned CHAN_BASE  = RANK_BASE + RANK_CHAN_BITS;
  localparam int unsigned TOTAL_SLOTS = CHAN_BASE + RANK_CHAN_BITS;
  localparam int unsigned SLOT_W     = 6;

  // Configuration port
  localparam int unsigned PADDR_W        = 3;
  localparam int unsigned PDATA_W        = 32;
  localparam logic [0:0]  REG_OFFSET_BITS = 1'b0;
  localparam logic [OFFSET_W-1:0] OFFSET_BITS_RST = 4'd6;

  // Request kinds (code 3 is a no-op)
  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_MAP   = 2'd1,
    KIND_UNMAP = 2'd2
  } kind_e;

  typedef logic [ADDR_BITS-1:0]                  addr_t;
  typedef logic [TOTAL_SLOTS-1:0][ADDR_BITS-1:0] slot_tbl_t;

  // Input tdata layout, lowest field last
  typedef struct packed {
    logic [1:0]                pad;
    logic [RANK_CHAN_BITS-1:0] channel;
    logic [RANK_CHAN_BITS-1:0] rank;
    logic [BANKGROUP_BITS-1:0] bankgroup;
    logic [BANK_BITS-1:0]      bank;
    logic [ROW_BITS-1:0]       row;
    logic [COL_BITS-1:0]       column;
    logic                      slot_direct;
    addr_t                     slot_mask;
    logic [SLOT_W-1:0]         slot;
    addr_t                     address;
  } in_data_t;

  // Output tdata layout, lowest field last
  typedef struct packed {
    logic [1:0]                pad;
    addr_t                     rebuilt_address;
    logic [BURST_W-1:0]        burst_offset;
    logic [RANK_CHAN_BITS-1:0] map_channel;
    logic [RANK_CHAN_BITS-1:0] map_rank;
    logic [BANKGROUP_BITS-1:0] map_bankgroup;
    logic [BANK_BITS-1:0]      map_bank;
    logic [ROW_BITS-1:0]       map_row;
    logic [COL_BITS-1:0]       map_column;
  } out_data_t;

  localparam int unsigned IN_DATA_W  = $bits(in_data_t);
  localparam int unsigned OUT_DATA_W = $bits(out_data_t);

  // Slot table write request
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    addr_t             mask;
    logic              direct;
  } slot_wr_t;

endpackage

// ===== design/dxam_apb_regs.sv =====
// ----------------------------------------------------------------------------
// dxam_apb_regs
// APB register file holding the burst offset width.
// ----------------------------------------------------------------------------
module dxam_apb_regs (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [dxam_pkg::PADDR_W-1:0]           paddr,
  input  logic [dxam_pkg::PDATA_W-1:0]           pwdata,
  output logic [dxam_pkg::PDATA_W-1:0]           prdata,
  output logic                                   pready,
  output logic [dxam_pkg::OFFSET_W-1:0]          offset_bits_o
);

  logic [dxam_pkg::OFFSET_W-1:0] offset_bits_q, offset_bits_d;
  logic                          reg_hit;
  logic                          wr_en;

  // Register 0 sits at byte address 0; word index is paddr[2]
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == dxam_pkg::REG_OFFSET_BITS);
  assign wr_en   = psel && penable && pwrite && pready && reg_hit;

  always_comb begin
    offset_bits_d = offset_bits_q;
    if (wr_en) begin
      offset_bits_d = pwdata[dxam_pkg::OFFSET_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= dxam_pkg::OFFSET_BITS_RST;
    end else begin
      offset_bits_q <= offset_bits_d;
    end
  end

  // Read back
  assign prdata = reg_hit ? dxam_pkg::PDATA_W'(offset_bits_q) : '0;
  assign offset_bits_o = offset_bits_q;

endmodule

// ===== design/dxam_slot_table.sv =====
// ----------------------------------------------------------------------------
// dxam_slot_table
// Per-slot address masks plus the reverse-map bit position of each direct
// slot (lowest set mask bit), cleared at reset.
// ----------------------------------------------------------------------------
module dxam_slot_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dxam_pkg::slot_wr_t  wr_i,
  output dxam_pkg::slot_tbl_t mask_o,
  output dxam_pkg::slot_tbl_t dpos_o
);

  dxam_pkg::slot_tbl_t mask_q;
  dxam_pkg::slot_tbl_t dpos_q;
  dxam_pkg::addr_t     low_bit;
  dxam_pkg::addr_t     dpos_wr;

  // Isolate the lowest set mask bit; non-direct slots never write back
  assign low_bit = wr_i.mask & (~wr_i.mask + dxam_pkg::ADDR_BITS'(1));
  assign dpos_wr = wr_i.direct ? low_bit : '0;

  // Slots past the table end are simply never matched
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      dpos_q <= '0;
    end else begin
      for (int s = 0; s < dxam_pkg::TOTAL_SLOTS; s++) begin
        if (wr_i.en && (wr_i.slot == dxam_pkg::SLOT_W'(s))) begin
          mask_q[s] <= wr_i.mask;
          dpos_q[s] <= dpos_wr;
        end
      end
    end
  end

  assign mask_o = mask_q;
  assign dpos_o = dpos_q;

endmodule

// ===== design/dxam_map_core.sv =====
// ----------------------------------------------------------------------------
// dxam_map_core
// Forward XOR parity mapping and reverse address rebuild for one request.
// ----------------------------------------------------------------------------
module dxam_map_core (
  input  logic [1:0]                    kind_i,
  input  dxam_pkg::in_data_t            item_i,
  input  logic [dxam_pkg::OFFSET_W-1:0] offset_bits_i,
  input  dxam_pkg::slot_tbl_t           mask_i,
  input  dxam_pkg::slot_tbl_t           dpos_i,
  output dxam_pkg::out_data_t           res_o
);

  logic [dxam_pkg::TOTAL_SLOTS-1:0] par;
  logic [dxam_pkg::TOTAL_SLOTS-1:0] vals;
  logic [dxam_pkg::TOTAL_SLOTS-1:0] hit   [dxam_pkg::ADDR_BITS];
  logic [dxam_pkg::TOTAL_SLOTS-1:0] win   [dxam_pkg::ADDR_BITS];
  dxam_pkg::addr_t                  rebuilt;
  logic [15:0]                      off_full;
  logic [dxam_pkg::BURST_W-1:0]     off_bits;

  // Offset mask: offset_bits ones, at most 15
  assign off_full = (16'd1 << offset_bits_i) - 16'd1;
  assign off_bits = item_i.address[dxam_pkg::BURST_W-1:0] & off_full[dxam_pkg::BURST_W-1:0];

  // Forward: one parity tree per slot
  always_comb begin
    for (int s = 0; s < dxam_pkg::TOTAL_SLOTS; s++) begin
      par[s] = ^(item_i.address & mask_i[s]);
    end
  end

  // Reverse: per address bit, the highest direct slot aimed at it wins
  assign vals = {item_i.channel, item_i.rank, item_i.bankgroup,
                 item_i.bank, item_i.row, item_i.column};

  always_comb begin
    for (int b = 0; b < dxam_pkg::ADDR_BITS; b++) begin
      for (int s = 0; s < dxam_pkg::TOTAL_SLOTS; s++) begin
        hit[b][s] = dpos_i[s][b];
      end
      for (int s = 0; s < dxam_pkg::TOTAL_SLOTS; s++) begin
        win[b][s] = hit[b][s] && !(|(hit[b] >> (s + 1)));
      end
      rebuilt[b] = |(win[b] & vals);
    end
  end

  // Result assembly by request kind
  always_comb begin
    res_o = '0;
    case (kind_i)
      dxam_pkg::KIND_MAP: begin
        res_o.map_column    = par[dxam_pkg::COL_BASE  +: dxam_pkg::COL_BITS];
        res_o.map_row       = par[dxam_pkg::ROW_BASE  +: dxam_pkg::ROW_BITS];
        res_o.map_bank      = par[dxam_pkg::BANK_BASE +: dxam_pkg::BANK_BITS];
        res_o.map_bankgroup = par[dxam_pkg::BG_BASE   +: dxam_pkg::BANKGROUP_BITS];
        res_o.map_rank      = par[dxam_pkg::RANK_BASE +: dxam_pkg::RANK_CHAN_BITS];
        res_o.map_channel   = par[dxam_pkg::CHAN_BASE +: dxam_pkg::RANK_CHAN_BITS];
        res_o.burst_offset  = off_bits;
      end
      dxam_pkg::KIND_UNMAP: begin
        res_o.rebuilt_address = rebuilt | dxam_pkg::ADDR_BITS'(off_bits);
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

// ===== design/dram_xor_address_mapper.sv =====
// Flow: an accepted request waits in the input register; its result is registered into
// the output register as the request moves on, and is offered on m_axis from there.
// Throughput: one request per cycle unless m_axis stalls; a load request updates the
// slot table as it leaves the input register, seen by a map request right behind it.
// Reset: asynchronous, active low; slot table cleared, offset_bits set to 6, both
// pipeline stages empty. No clearing pass: requests are taken right after reset.
// ----------------------------------------------------------------------------
// dram_xor_address_mapper
// Maps physical addresses to DRAM column/row/bank/bankgroup/rank/channel by
// XOR parity over loadable slot masks, and rebuilds addresses in reverse.
// ----------------------------------------------------------------------------
module dram_xor_address_mapper (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Request stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: address, slot, slot_mask, slot_direct, column, row, bank,
  //        bankgroup, rank, channel, zero pad
  input  logic [dxam_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: kind
  input  logic [1:0]                         s_axis_tuser,
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: map_column, map_row, map_bank, map_bankgroup, map_rank,
  //        map_channel, burst_offset, rebuilt_address, zero pad
  output logic [dxam_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // Configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dxam_pkg::PADDR_W-1:0]       paddr,
  input  logic [dxam_pkg::PDATA_W-1:0]       pwdata,
  output logic [dxam_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);

  logic                          in_valid_q, in_valid_d;
  logic [1:0]                    kind_q;
  dxam_pkg::in_data_t            item_q;
  logic                          out_valid_q, out_valid_d;
  dxam_pkg::out_data_t           res_q;
  dxam_pkg::out_data_t           res_d;
  logic                          adv;
  logic                          in_acc;
  logic                          has_result;
  logic [dxam_pkg::OFFSET_W-1:0] offset_bits;
  dxam_pkg::slot_wr_t            slot_wr;
  dxam_pkg::slot_tbl_t           mask_tbl;
  dxam_pkg::slot_tbl_t           dpos_tbl;

  dxam_apb_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .offset_bits_o (offset_bits)
  );

  // Pipeline flow control
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign has_result    = (kind_q == dxam_pkg::KIND_MAP) || (kind_q == dxam_pkg::KIND_UNMAP);

  // Slot load as the request leaves the input register
  always_comb begin
    slot_wr.en     = in_valid_q && adv && (kind_q == dxam_pkg::KIND_LOAD);
    slot_wr.slot   = item_q.slot;
    slot_wr.mask   = item_q.slot_mask;
    slot_wr.direct = item_q.slot_direct;
  end

  dxam_slot_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (slot_wr),
    .mask_o (mask_tbl),
    .dpos_o (dpos_tbl)
  );

  dxam_map_core u_core (
    .kind_i        (kind_q),
    .item_i        (item_q),
    .offset_bits_i (offset_bits),
    .mask_i        (mask_tbl),
    .dpos_i        (dpos_tbl),
    .res_o         (res_d)
  );

  // Stage valids
  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      in_valid_d  = 1'b0;
      out_valid_d = in_valid_q && has_result;
    end
    if (in_acc) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= dxam_pkg::in_data_t'(s_axis_tdata);
      kind_q <= s_axis_tuser;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

  // A map or unmap request moving on always yields a result
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && adv && has_result) |=> out_valid_q)
    else $error("map request lost between stages");

  // Loads and no-ops never yield a result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && adv && !has_result) |=> !out_valid_q)
    else $error("result produced for load or no-op request");

  // A stalled input stage keeps its request
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !adv) |=> (in_valid_q && $stable(item_q) && $stable(kind_q)))
    else $error("input stage changed while stalled");

endmodule

// ===== tb/sv/dxam_map_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dxam_map_checker
// Watches the request, result and configuration channels of the DRAM XOR
// address mapper. Keeps its own copy of the slot table and of offset_bits,
// works out the result of each accepted request and compares every result
// that leaves the block, field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module dxam_map_checker
  import dxam_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  input  logic                    s_axis_tready,
  input  logic [IN_DATA_W-1:0]    s_axis_tdata,
  input  logic [1:0]              s_axis_tuser,
  input  logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  input  logic [OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  input  logic                    pready,
  output int unsigned             mismatch_count_o,
  output int unsigned             pending_count_o
);

  // Shadow of the block's slot table and register
  addr_t               mask_tbl   [TOTAL_SLOTS];
  logic                direct_tbl [TOTAL_SLOTS];
  logic [OFFSET_W-1:0] offset_cfg;

  // Results owed by the block, oldest first
  out_data_t   owed_results [$];
  out_data_t   want_res;
  out_data_t   got_res;
  in_data_t    req;
  int unsigned mismatches = 0;

  function automatic addr_t offset_ones(logic [OFFSET_W-1:0] n);
    return (addr_t'(1) << n) - addr_t'(1);
  endfunction

  // Forward map: each component bit is the parity of its masked address bits
  function automatic out_data_t map_forward(addr_t addr);
    logic [TOTAL_SLOTS-1:0] comp_bits;
    out_data_t              r;
    for (int s = 0; s < TOTAL_SLOTS; s++) begin
      comp_bits[s] = ^(addr & mask_tbl[s]);
    end
    r = '0;
    r.map_column    = comp_bits[COL_BASE +: COL_BITS];
    r.map_row       = comp_bits[ROW_BASE +: ROW_BITS];
    r.map_bank      = comp_bits[BANK_BASE +: BANK_BITS];
    r.map_bankgroup = comp_bits[BG_BASE +: BANKGROUP_BITS];
    r.map_rank      = comp_bits[RANK_BASE +: RANK_CHAN_BITS];
    r.map_channel   = comp_bits[CHAN_BASE +: RANK_CHAN_BITS];
    r.burst_offset  = BURST_W'(addr & offset_ones(offset_cfg));
    return r;
  endfunction

  // Reverse map: direct slots write their bit at the lowest set mask bit,
  // later slots override earlier ones, offset bits are ORed in last
  function automatic addr_t map_reverse(in_data_t d);
    logic [TOTAL_SLOTS-1:0] comp_bits;
    addr_t                  rebuilt;
    addr_t                  pos;
    comp_bits = {d.channel, d.rank, d.bankgroup, d.bank, d.row, d.column};
    rebuilt   = '0;
    for (int s = 0; s < TOTAL_SLOTS; s++) begin
      if (direct_tbl[s] && mask_tbl[s] != '0) begin
        pos = mask_tbl[s] & (~mask_tbl[s] + addr_t'(1));
        if (comp_bits[s]) begin
          rebuilt |= pos;
        end else begin
          rebuilt &= ~pos;
        end
      end
    end
    return rebuilt | (d.address & offset_ones(offset_cfg));
  endfunction

  task automatic note_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < TOTAL_SLOTS; s++) begin
        mask_tbl[s]   = '0;
        direct_tbl[s] = 1'b0;
      end
      offset_cfg = OFFSET_BITS_RST;
      owed_results.delete();
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      // Result leaving the block
      if (m_axis_tvalid && m_axis_tready) begin
        got_res = m_axis_tdata;
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result 0x%0h with none expected", $time, got_res);
          end
        end else begin
          want_res = owed_results.pop_front();
          note_field("map_column", 64'(want_res.map_column), 64'(got_res.map_column));
          note_field("map_row", 64'(want_res.map_row), 64'(got_res.map_row));
          note_field("map_bank", 64'(want_res.map_bank), 64'(got_res.map_bank));
          note_field("map_bankgroup", 64'(want_res.map_bankgroup),
                     64'(got_res.map_bankgroup));
          note_field("map_rank", 64'(want_res.map_rank), 64'(got_res.map_rank));
          note_field("map_channel", 64'(want_res.map_channel), 64'(got_res.map_channel));
          note_field("burst_offset", 64'(want_res.burst_offset),
                     64'(got_res.burst_offset));
          note_field("rebuilt_address", 64'(want_res.rebuilt_address),
                     64'(got_res.rebuilt_address));
        end
      end

      // Request entering the block
      if (s_axis_tvalid && s_axis_tready) begin
        req = s_axis_tdata;
        case (s_axis_tuser)
          KIND_LOAD: begin
            if (req.slot < TOTAL_SLOTS) begin
              mask_tbl[req.slot]   = req.slot_mask;
              direct_tbl[req.slot] = req.slot_direct;
            end
          end
          KIND_MAP: begin
            want_res = map_forward(req.address);
            owed_results.insert(owed_results.size(), want_res);
          end
          KIND_UNMAP: begin
            want_res = '0;
            want_res.rebuilt_address = map_reverse(req);
            owed_results.insert(owed_results.size(), want_res);
          end
          default: begin
            // unused kind, nothing happens
          end
        endcase
      end

      // Register write
      if (psel && penable && pwrite && pready
          && paddr[PADDR_W-1:2] == REG_OFFSET_BITS) begin
        offset_cfg = pwdata[OFFSET_W-1:0];
      end

      mismatch_count_o <= mismatches;
      pending_count_o  <= owed_results.size();
    end
  end

endmodule

// ===== tb/sv/dram_xor_address_mapper_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dram_xor_address_mapper_tb
// Drives slot loads, forward and reverse map requests into the address
// mapper under random stalls on both streams, changes offset_bits between
// phases, and reports the verdict from the checker's counts.
// ----------------------------------------------------------------------------
module dram_xor_address_mapper_tb;
  import dxam_pkg::*;

  localparam logic [1:0]  KIND_NOP    = 2'd3;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned PHASE_OPS   = 200;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // tdata: address, slot, slot_mask, slot_direct, column, row, bank,
  //        bankgroup, rank, channel, zero pad
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  // tuser: kind
  logic [1:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // tdata: map_column, map_row, map_bank, map_bankgroup, map_rank,
  //        map_channel, burst_offset, rebuilt_address, zero pad
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [PADDR_W-1:0]    paddr         = '0;
  logic [PDATA_W-1:0]    pwdata        = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  int unsigned mismatch_count;
  int unsigned pending_count;
  bit          hold_off_req = 1'b0;
  bit          gaps_on      = 1'b1;

  dram_xor_address_mapper DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  dxam_map_checker map_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mostly short idle gaps, now and then a long one
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 15) == 0) begin
      return $urandom_range(20, 60);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic addr_t random_addr();
    return addr_t'({$urandom, $urandom});
  endfunction

  // All fields random, pad zero; callers override what the kind uses
  function automatic in_data_t random_fields();
    in_data_t r;
    r             = '0;
    r.address     = random_addr();
    r.slot        = SLOT_W'($urandom);
    r.slot_mask   = random_addr();
    r.slot_direct = 1'($urandom);
    r.column      = COL_BITS'($urandom);
    r.row         = ROW_BITS'($urandom);
    r.bank        = BANK_BITS'($urandom);
    r.bankgroup   = BANKGROUP_BITS'($urandom);
    r.rank        = RANK_CHAN_BITS'($urandom);
    r.channel     = RANK_CHAN_BITS'($urandom);
    return r;
  endfunction

  // Offer one request and return at the edge that accepts it
  task automatic send_req(logic [1:0] kind, in_data_t req);
    int unsigned idle;
    idle = (gaps_on && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (idle != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic load_slot(int unsigned slot, addr_t mask, logic direct);
    in_data_t req;
    req             = random_fields();
    req.slot        = SLOT_W'(slot);
    req.slot_mask   = mask;
    req.slot_direct = direct;
    send_req(KIND_LOAD, req);
  endtask

  task automatic map_addr(addr_t addr);
    in_data_t req;
    req         = random_fields();
    req.address = addr;
    send_req(KIND_MAP, req);
  endtask

  // comps holds channel..column with column in the low bits
  task automatic unmap_comps(logic [TOTAL_SLOTS-1:0] comps, addr_t addr);
    in_data_t req;
    req = random_fields();
    {req.channel, req.rank, req.bankgroup, req.bank, req.row, req.column} = comps;
    req.address = addr;
    send_req(KIND_UNMAP, req);
  endtask

  // Drop valid, wait for every owed result, then let the pipe settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_offset_bits(logic [OFFSET_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_OFFSET_BITS, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: alternating ready runs and stalls, plus one long hold-off
  initial begin : result_sink
    bit          accept;
    int unsigned run;
    accept = 1'b1;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        m_axis_tready <= accept;
        if (accept) begin
          run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                            : $urandom_range(1, 8);
        end else begin
          run = gap_len();
        end
        repeat (run) @(posedge clk_i);
        accept = !accept;
      end
    end
  end

  initial begin : stimulus
    int unsigned         bit_order [ADDR_BITS];
    int unsigned         j;
    int unsigned         tmp;
    int unsigned         pick;
    addr_t               mask;
    in_data_t            req;
    logic [OFFSET_W-1:0] phase_offset;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, ignored loads, odd masks, overlaps
    map_addr('1);
    unmap_comps('1, '1);
    req = random_fields();
    send_req(KIND_NOP, req);
    load_slot(TOTAL_SLOTS, '1, 1'b1);
    load_slot(63, '1, 1'b1);
    map_addr('1);
    load_slot(COL_BASE, '1, 1'b0);
    load_slot(TOTAL_SLOTS - 1, addr_t'(1) << (ADDR_BITS - 1), 1'b1);
    load_slot(COL_BASE + 1, addr_t'(12'hA00), 1'b1);
    load_slot(COL_BASE + 2, '0, 1'b1);
    load_slot(ROW_BASE, addr_t'(1) << 20, 1'b1);
    load_slot(ROW_BASE + 1, addr_t'(1) << 20, 1'b1);
    load_slot(BANK_BASE, addr_t'(1) << 3, 1'b1);
    map_addr('1);
    map_addr('0);
    map_addr(addr_t'(40'hAA_AAAA_AAAA));
    map_addr(addr_t'(40'h55_5555_5555));
    unmap_comps('1, '0);
    unmap_comps('0, '1);
    // column bit 1 set, both overlapping row slots hit bit 20
    unmap_comps(39'h1002, addr_t'(6'h3F));
    unmap_comps(39'h2000, '0);
    unmap_comps(39'h40_0000_0000, '0);

    // Random phases, each with its own offset_bits and slot table
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0:       phase_offset = '0;
        1:       phase_offset = '1;
        4:       phase_offset = OFFSET_W'(1);
        5:       phase_offset = OFFSET_W'(14);
        default: phase_offset = OFFSET_W'($urandom);
      endcase
      write_offset_bits(phase_offset);
      gaps_on = (ph % 3 != 2);
      if (ph == 2) begin
        hold_off_req = 1'b1;
      end

      // Shuffle address bits so direct slots mostly land on distinct bits
      for (int i = 0; i < ADDR_BITS; i++) begin
        bit_order[i] = i;
      end
      for (int i = ADDR_BITS - 1; i > 0; i--) begin
        j            = $urandom_range(0, i);
        tmp          = bit_order[i];
        bit_order[i] = bit_order[j];
        bit_order[j] = tmp;
      end

      // Well-formed table: one-hot masks, some XOR-folded, a few empty
      for (int s = 0; s < TOTAL_SLOTS; s++) begin
        mask = addr_t'(1) << bit_order[s];
        if ($urandom_range(0, 19) == 0) begin
          mask = addr_t'(1) << bit_order[$urandom_range(0, ADDR_BITS - 1)];
        end
        if ($urandom_range(0, 3) == 0) begin
          mask |= random_addr() & random_addr() & random_addr();
        end
        if ($urandom_range(0, 19) == 0) begin
          mask = '0;
        end
        load_slot(s, mask, $urandom_range(0, 4) != 0);
      end

      // Mostly map and reverse map requests, some reloads and noise
      for (int n = 0; n < PHASE_OPS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          map_addr(random_addr());
        end else if (pick < 90) begin
          unmap_comps(TOTAL_SLOTS'({$urandom, $urandom}), random_addr());
        end else if (pick < 96) begin
          load_slot(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                : $urandom_range(0, TOTAL_SLOTS - 1),
                    random_addr() & random_addr(), 1'($urandom));
        end else begin
          req = random_fields();
          send_req(KIND_NOP, req);
        end
      end
    end

    wait_idle();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
